// ===== rtl/vfc_pkg.sv =====
`default_nettype none
package vfc_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_PLANES = 6;

	localparam logic [2:0] MODE_LOAD = 3'd0;
	localparam logic [2:0] MODE_POINT = 3'd1;
	localparam logic [2:0] MODE_SPHERE = 3'd2;
	localparam logic [2:0] MODE_BOX = 3'd3;
	localparam logic [2:0] MODE_BOXVIS = 3'd4;

	typedef struct packed {
		logic [2:0] mode;
		logic [3:0] element_index;
		logic signed [31:0] element_value;
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] lo_z;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
		logic signed [31:0] hi_z;
		logic [30:0] radius;
		logic [5:0] active_mask;
	} in_word_t;

	typedef struct packed {
		logic inside_res;
		logic culled;
		logic [5:0] mask_out;
	} out_word_t;

	typedef struct packed {
		logic valid;
		logic [2:0] mode;
		logic alive;
		logic culled;
		logic [5:0] mask;
	} cell_ctl_t;

	localparam logic [1:0] PLANE_ROW [NUM_PLANES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
	localparam logic PLANE_ADD [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
endpackage
`default_nettype wire

// ===== rtl/vfc_cell.sv =====
`default_nettype none
module vfc_cell #(
	parameter int WORD_BITS = vfc_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF,
	parameter int PLANE = 0
) (
	input wire clk,
	input wire arst_n,
	input wire advance,
	input wire signed [WORD_BITS:0] nx,
	input wire signed [WORD_BITS:0] ny,
	input wire signed [WORD_BITS:0] nz,
	input wire signed [WORD_BITS:0] nw,
	input wire vfc_pkg::cell_ctl_t ctl_in,
	input wire vfc_pkg::in_word_t item_in,
	output vfc_pkg::cell_ctl_t ctl_out,
	output vfc_pkg::in_word_t item_out
);
	localparam int PW = 2 * WORD_BITS + 6;

	vfc_pkg::cell_ctl_t ctl_q;
	vfc_pkg::in_word_t item_q;
	logic signed [PW-1:0] px, py, pz, qx, qy, qz, sx, sy, sz, ex, ey, ez, w1, d, d2, t2, rr;
	logic signed [PW-1:0] dr, dbox;
	logic signed [WORD_BITS:0] lx, ly, lz, hx, hy, hz;
	logic [5:0] bit_m;
	logic pass;
	vfc_pkg::cell_ctl_t nxt;

	function automatic logic signed [PW-1:0] absv(input logic signed [PW-1:0] v);
		return v[PW-1] ? -v : v;
	endfunction

	always_comb begin
		lx = (WORD_BITS+1)'(WORD_BITS'(item_in.lo_x));
		ly = (WORD_BITS+1)'(WORD_BITS'(item_in.lo_y));
		lz = (WORD_BITS+1)'(WORD_BITS'(item_in.lo_z));
		hx = (WORD_BITS+1)'(WORD_BITS'(item_in.hi_x));
		hy = (WORD_BITS+1)'(WORD_BITS'(item_in.hi_y));
		hz = (WORD_BITS+1)'(WORD_BITS'(item_in.hi_z));
		px = PW'(nx) * PW'(lx);
		py = PW'(ny) * PW'(ly);
		pz = PW'(nz) * PW'(lz);
		qx = PW'(nx) * PW'(hx);
		qy = PW'(ny) * PW'(hy);
		qz = PW'(nz) * PW'(hz);
		sx = px + qx;
		sy = py + qy;
		sz = pz + qz;
		ex = absv(qx - px);
		ey = absv(qy - py);
		ez = absv(qz - pz);
		w1 = PW'(nw) <<< FRAC_BITS;
		rr = PW'({1'b0, item_in.radius}) <<< FRAC_BITS;
		d = w1 + px + py + pz;
		dr = d + rr;
		dbox = w1 + ((px < qx) ? qx : px) + ((py < qy) ? qy : py) + ((pz < qz) ? qz : pz);
		d2 = (w1 <<< 1) + sx + sy + sz;
		t2 = ex + ey + ez;
		bit_m = 6'(1) << PLANE;
		nxt = ctl_in;
		unique case (ctl_in.mode)
			vfc_pkg::MODE_POINT: pass = !d[PW-1] && (d != '0);
			vfc_pkg::MODE_SPHERE: pass = !dr[PW-1] && (dr != '0);
			vfc_pkg::MODE_BOX: pass = !dbox[PW-1];
			default: pass = 1'b1;
		endcase
		if (ctl_in.mode == vfc_pkg::MODE_BOXVIS) begin
			if (ctl_in.alive && ctl_in.mask[PLANE]) begin
				if (d2[PW-1]) begin
					if (t2 < -d2) begin
						nxt.culled = 1'b1;
						nxt.alive = 1'b0;
						nxt.mask = '0;
					end
				end else if (t2 < d2) begin
					nxt.mask = ctl_in.mask & ~bit_m;
				end
			end
		end else if (!pass) begin
			nxt.alive = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= item_in;
		end
	end

	assign ctl_out = ctl_q;
	assign item_out = item_q;
endmodule
`default_nettype wire

// ===== rtl/view_frustum_culling.sv =====
`default_nettype none
// Channel  Direction  Handshake
// in       input      in_valid / in_stall
// out      output     out_valid / out_stall
// cfg      input      cfg_valid / cfg_ready
// One test word enters per cycle unless stalled; it passes one registered cell per plane.
// A load word waits while a test is still in any cell register but the last.
// Loads write the matrix at acceptance; tests see every load accepted before them.
// Reset clears the matrix, the layout register and all cell valid bits.
// A stall on a valid output word holds the whole cell chain and stalls the input.
module view_frustum_culling #(
	parameter int WORD_BITS = vfc_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input wire vfc_pkg::in_word_t in_word,
	output logic out_valid,
	input wire out_stall,
	output vfc_pkg::out_word_t out_word,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire cfg_data
);
	localparam int N = vfc_pkg::NUM_PLANES;

	logic [WORD_BITS-1:0] mat_q [16];
	logic layout_q;
	logic advance;
	logic load_hold;
	vfc_pkg::cell_ctl_t ctl [N+1];
	vfc_pkg::in_word_t item [N+1];
	logic signed [WORD_BITS:0] pl [N][4];

	always_comb begin
		load_hold = 1'b0;
		for (int g = 1; g < N; g++) begin
			if (ctl[g].valid) load_hold = 1'b1;
		end
	end

	assign advance = !(ctl[N].valid && out_stall);
	assign in_stall = !advance || (in_word.mode == vfc_pkg::MODE_LOAD && load_hold);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else begin
			if (cfg_valid) layout_q <= cfg_data;
			if (in_valid && !in_stall && in_word.mode == vfc_pkg::MODE_LOAD)
				mat_q[in_word.element_index] <= WORD_BITS'(in_word.element_value);
		end
	end

	always_comb begin
		logic [3:0] ia, ib;
		for (int i = 0; i < N; i++) begin
			for (int c = 0; c < 4; c++) begin
				ia = layout_q ? 4'(12 + c) : 4'(c * 4 + 3);
				ib = layout_q ? 4'(vfc_pkg::PLANE_ROW[i] * 4 + c)
					: 4'(c * 4 + vfc_pkg::PLANE_ROW[i]);
				pl[i][c] = vfc_pkg::PLANE_ADD[i]
					? $signed({mat_q[ia][WORD_BITS-1], mat_q[ia]})
						+ $signed({mat_q[ib][WORD_BITS-1], mat_q[ib]})
					: $signed({mat_q[ia][WORD_BITS-1], mat_q[ia]})
						- $signed({mat_q[ib][WORD_BITS-1], mat_q[ib]});
			end
		end
	end

	always_comb begin
		ctl[0].valid = in_valid && (in_word.mode == vfc_pkg::MODE_POINT
			|| in_word.mode == vfc_pkg::MODE_SPHERE || in_word.mode == vfc_pkg::MODE_BOX
			|| in_word.mode == vfc_pkg::MODE_BOXVIS);
		ctl[0].mode = in_word.mode;
		ctl[0].alive = 1'b1;
		ctl[0].culled = 1'b0;
		ctl[0].mask = in_word.active_mask;
		item[0] = in_word;
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		vfc_cell #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS), .PLANE(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.nx(pl[g][0]), .ny(pl[g][1]), .nz(pl[g][2]), .nw(pl[g][3]),
			.ctl_in(ctl[g]), .item_in(item[g]),
			.ctl_out(ctl[g+1]), .item_out(item[g+1])
		);
	end

	always_comb begin
		out_valid = ctl[N].valid;
		out_word.inside_res = ctl[N].alive;
		out_word.culled = (ctl[N].mode == vfc_pkg::MODE_BOXVIS) && ctl[N].culled;
		out_word.mask_out = (ctl[N].mode == vfc_pkg::MODE_BOXVIS) ? ctl[N].mask : 6'd0;
	end
endmodule
`default_nettype wire

// ===== tb/view_frustum_culling_test.sv =====
`default_nettype none
module view_frustum_culling_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	vfc_pkg::in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vfc_pkg::out_word_t out_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	logic signed [31:0] matrix [16];
	logic layout;
	vfc_pkg::out_word_t pending_results [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	view_frustum_culling DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic logic signed [32:0] elem(int row, int col);
		return 33'(matrix[layout ? row * 4 + col : col * 4 + row]);
	endfunction

	function automatic logic signed [32:0] plane_coef(int p, int c);
		logic signed [32:0] a;
		logic signed [32:0] b;
		a = elem(3, c);
		b = elem(vfc_pkg::PLANE_ROW[p], c);
		return vfc_pkg::PLANE_ADD[p] ? a + b : a - b;
	endfunction

	function automatic vfc_pkg::out_word_t cull_result(vfc_pkg::in_word_t w);
		vfc_pkg::out_word_t r;
		logic signed [127:0] d;
		logic signed [127:0] t;
		logic signed [127:0] a;
		logic signed [127:0] b;
		logic signed [32:0] lo [3];
		logic signed [32:0] hi [3];
		logic [5:0] mask;
		r = '0;
		r.inside_res = 1'b1;
		mask = w.active_mask;
		lo[0] = 33'(w.lo_x); lo[1] = 33'(w.lo_y); lo[2] = 33'(w.lo_z);
		hi[0] = 33'(w.hi_x); hi[1] = 33'(w.hi_y); hi[2] = 33'(w.hi_z);
		for (int p = 0; p < vfc_pkg::NUM_PLANES; p++) begin
			if (w.mode == vfc_pkg::MODE_POINT || w.mode == vfc_pkg::MODE_SPHERE) begin
				d = 128'(plane_coef(p, 3)) <<< FRAC;
				for (int c = 0; c < 3; c++) d += 128'(plane_coef(p, c)) * 128'(lo[c]);
				if (w.mode == vfc_pkg::MODE_SPHERE) d += 128'({1'b0, w.radius}) <<< FRAC;
				if (d <= 0) begin
					r.inside_res = 1'b0;
					break;
				end
			end else if (w.mode == vfc_pkg::MODE_BOX) begin
				d = 128'(plane_coef(p, 3)) <<< FRAC;
				for (int c = 0; c < 3; c++) begin
					a = 128'(plane_coef(p, c)) * 128'(lo[c]);
					b = 128'(plane_coef(p, c)) * 128'(hi[c]);
					d += (a < b) ? b : a;
				end
				if (d < 0) begin
					r.inside_res = 1'b0;
					break;
				end
			end else if (mask[p]) begin
				d = 128'(plane_coef(p, 3)) <<< (FRAC + 1);
				t = 0;
				for (int c = 0; c < 3; c++) begin
					d += 128'(plane_coef(p, c)) * 128'(lo[c] + hi[c]);
					a = 128'(plane_coef(p, c)) * 128'(hi[c] - lo[c]);
					t += (a < 0) ? -a : a;
				end
				if (d < 0) begin
					if (t < -d) begin
						r.culled = 1'b1;
						mask = '0;
						break;
					end
				end else if (t < d) begin
					mask[p] = 1'b0;
				end
			end
		end
		if (w.mode == vfc_pkg::MODE_BOXVIS) begin
			r.inside_res = ~r.culled;
			r.mask_out = mask;
		end
		return r;
	endfunction

	task automatic send_word(vfc_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		if (w.mode == vfc_pkg::MODE_LOAD) matrix[w.element_index] = w.element_value;
		else if (w.mode <= vfc_pkg::MODE_BOXVIS) pending_results.push_back(cull_result(w));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_layout(logic v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		layout = v;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'($urandom);
			default: return 32'($signed($urandom_range(40, 0)) - 20) <<< FRAC;
		endcase
	endfunction

	function automatic vfc_pkg::in_word_t rand_test(logic [2:0] mode);
		vfc_pkg::in_word_t w;
		w = vfc_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		w.mode = mode;
		w.lo_x = rand_coord(); w.lo_y = rand_coord(); w.lo_z = rand_coord();
		w.hi_x = rand_coord(); w.hi_y = rand_coord(); w.hi_z = rand_coord();
		if ($urandom_range(1)) w.radius = 31'($urandom_range(8, 0)) << FRAC;
		return w;
	endfunction

	task automatic load_element(int idx, logic signed [31:0] v);
		vfc_pkg::in_word_t w;
		w = vfc_pkg::in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		w.mode = vfc_pkg::MODE_LOAD;
		w.element_index = 4'(idx);
		w.element_value = v;
		send_word(w);
	endtask

	task automatic load_identity();
		for (int i = 0; i < 16; i++)
			load_element(i, (i % 5 == 0) ? 32'sh0001_0000 : 32'sh0);
	endtask

	task automatic test_directed();
		vfc_pkg::in_word_t w;
		for (int m = vfc_pkg::MODE_POINT; m <= vfc_pkg::MODE_BOXVIS; m++)
			send_word(rand_test(3'(m)));
		load_identity();
		w = rand_test(vfc_pkg::MODE_POINT);
		w.lo_x = 0; w.lo_y = 0; w.lo_z = 0;
		send_word(w);
		w.lo_x = 32'sh0001_0000;
		send_word(w);
		w.mode = vfc_pkg::MODE_SPHERE; w.lo_x = 32'sh0003_0000; w.radius = 31'h0002_0000;
		send_word(w);
		w.radius = 31'h7fff_ffff;
		send_word(w);
		w.mode = vfc_pkg::MODE_BOX; w.lo_x = 32'sh7fff_ffff; w.hi_x = 32'sh8000_0000;
		send_word(w);
		w.mode = vfc_pkg::MODE_BOXVIS; w.active_mask = 6'h3f;
		send_word(w);
		w.active_mask = '0;
		send_word(w);
		for (int m = 5; m <= 7; m++) begin
			w.mode = 3'(m);
			send_word(w);
		end
		load_element(15, 32'sh7fff_ffff);
		load_element(0, 32'sh8000_0000);
		send_word(rand_test(vfc_pkg::MODE_BOX));
	endtask

	task automatic test_random(int count);
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 15) load_element($urandom_range(15),
				$urandom_range(3) == 0 ? 32'($urandom) : rand_coord());
			else if (r < 18) send_word(rand_test(3'($urandom_range(7, 5))));
			else send_word(rand_test(3'($urandom_range(vfc_pkg::MODE_BOXVIS,
				vfc_pkg::MODE_POINT))));
			if (n == count / 2) wait_drained();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word %h", out_word);
					fail_count++;
				end else begin
					vfc_pkg::out_word_t e;
					e = pending_results.pop_front();
					if (out_word.inside_res !== e.inside_res) begin
						$error("inside_res expected %0d actual %0d", e.inside_res,
							out_word.inside_res);
						fail_count++;
					end
					if (out_word.culled !== e.culled) begin
						$error("culled expected %0d actual %0d", e.culled, out_word.culled);
						fail_count++;
					end
					if (out_word.mask_out !== e.mask_out) begin
						$error("mask_out expected %h actual %h", e.mask_out, out_word.mask_out);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 16; i++) matrix[i] = '0;
		layout = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_layout(1'b1);
		send_idle_pct = 10;
		recv_stall_pct = 47;
		test_random(320);
		write_layout(1'b0);
		send_idle_pct = 47;
		recv_stall_pct = 10;
		test_random(320);
		write_layout(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(310);
		wait_drained();
		if (fail_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
